### hdl/gradient_stop_color_lookup_assert.svh
// Assertion macros for the gradient stop lookup block.
// Used by the top level; expects signals clk and rst in the scope of use.
`ifndef GRADIENT_STOP_COLOR_LOOKUP_ASSERT_SVH
`define GRADIENT_STOP_COLOR_LOOKUP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GSCL_ASSERT_ALWAYS(label, expr) label: assert property (@(posedge clk) \
  disable iff (rst) (expr)) else $error("gscl invariant violated");
`define GSCL_ASSERT_IMPLY(label, ante, cons) label: assert property (@(posedge clk) \
  disable iff (rst) (ante) |-> (cons)) else $error("gscl implication violated");
`else
`define GSCL_ASSERT_ALWAYS(label, expr)
`define GSCL_ASSERT_IMPLY(label, ante, cons)
`endif
`endif

### hdl/gscl_pkg.sv
// Shared constants for the gradient stop lookup block.
// No dependencies; imported by gscl_div and the top level.
package gscl_pkg;
  localparam int MAX_STOPS_DEF    = 16;
  localparam int CHANNEL_BITS_DEF = 16;
  localparam int OFF_W            = 17;
  localparam int FRAC_W           = 16;
  localparam logic [OFF_W-1:0] OFF_ONE = 17'd65536;

  localparam logic [2:0] CMD_LOOKUP        = 3'd0;
  localparam logic [2:0] CMD_APPEND        = 3'd1;
  localparam logic [2:0] CMD_APPEND_INTERP = 3'd2;
  localparam logic [2:0] CMD_REMOVE        = 3'd3;
  localparam logic [2:0] CMD_RESTORE       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_INDEX = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;
endpackage

### hdl/gscl_stop_ram.sv
// Stop table storage: one write port, one read port with registered data.
// Depends on nothing but its parameters.
module gscl_stop_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 81
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/gscl_div.sv
// Restoring divider for the blend factor, one quotient bit per cycle.
// Depends on gscl_pkg; requires dividend below divisor.
module gscl_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [gscl_pkg::OFF_W-1:0]   dividend,
  input  logic [gscl_pkg::OFF_W-1:0]   divisor,
  output logic [gscl_pkg::FRAC_W-1:0]  quot,
  output logic                         done
);
  import gscl_pkg::*;

  localparam int CNT_W = $clog2(FRAC_W);

  logic [OFF_W-1:0] rem;
  logic [OFF_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [OFF_W:0]   trial;
  logic             fits;

  assign trial = {rem, 1'b0};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= dividend;
        dvs  <= divisor;
        quot <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        // The remainder stays below the divisor, so it fits back in OFF_W bits.
        rem  <= fits ? OFF_W'(trial - {1'b0, dvs}) : trial[OFF_W-1:0];
        quot <= {quot[FRAC_W-2:0], fits};
        cnt  <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(FRAC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### hdl/gradient_stop_color_lookup.sv
// Top level of the gradient stop lookup block: sequencer, scan and blend.
// Depends on gscl_pkg, gscl_stop_ram, gscl_div and the assertion header.
//
// One word is taken at a time; in_stall is high until its result has been
// placed in the output register, which can hold one finished result while
// the next word is worked on. A lookup reads the stop table one entry per
// cycle through the single read port; then, if the query falls between two
// stops with no exact match, a blend runs the serial divider and then the
// one multiplier shared by all four channels. A remove moves each later
// stop down one place. After reset the block writes the default stops
// before it takes a word.
module gradient_stop_color_lookup #(
  parameter int MAX_STOPS    = gscl_pkg::MAX_STOPS_DEF,
  parameter int CHANNEL_BITS = gscl_pkg::CHANNEL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [16:0] query_offset,
  input  logic [15:0] color_red,
  input  logic [15:0] color_green,
  input  logic [15:0] color_blue,
  input  logic [15:0] color_alpha,
  input  logic [3:0]  stop_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue,
  output logic [15:0] out_alpha,
  output logic        any_transparent,
  output logic [4:0]  stops_held,
  output logic [1:0]  status
);
  import gscl_pkg::*;

  localparam int CB   = CHANNEL_BITS;
  localparam int IW   = $clog2(MAX_STOPS);
  localparam int TW   = $clog2(MAX_STOPS + 1);
  localparam int CMPW = (TW > 4) ? TW : 4;
  localparam int WW   = OFF_W + 4 * CB;
  localparam int PW   = CB + FRAC_W + 2;
  localparam logic [CB-1:0] CH_FULL = {CB{1'b1}};

  typedef logic [3:0][CB-1:0] color_t;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_INIT0 = 15'b000000000000010,
    S_INIT1 = 15'b000000000000100,
    S_SCAN  = 15'b000000000001000,
    S_PICK  = 15'b000000000010000,
    S_DIV   = 15'b000000000100000,
    S_MUL   = 15'b000000001000000,
    S_ADD   = 15'b000000010000000,
    S_APP   = 15'b000000100000000,
    S_RM0   = 15'b000001000000000,
    S_RM1   = 15'b000010000000000,
    S_RMNX  = 15'b000100000000000,
    S_RMRD  = 15'b001000000000000,
    S_RMWR  = 15'b010000000000000,
    S_EMIT  = 15'b100000000000000
  } state_t;

  state_t           state;
  logic             boot;
  logic [2:0]       cmd_r;
  logic [OFF_W-1:0] q_r;
  color_t           col;
  logic [1:0]       status_r;
  logic [TW-1:0]    total;
  logic [TW-1:0]    tcnt;
  logic [TW-1:0]    iss;
  logic             rd_v;
  logic             rd_first;
  logic [IW-1:0]    cur;
  logic [TW-1:0]    cur1;
  logic [1:0]       ch;

  logic [OFF_W-1:0] min_off, max_off, lo_off, hi_off;
  color_t           min_col, max_col, lo_col, hi_col;
  logic             lo_v, hi_v;
  logic [FRAC_W-1:0] fac;
  logic signed [PW-1:0] prod;

  logic             we;
  logic [IW-1:0]    waddr, raddr;
  logic [WW-1:0]    wdata, rdata;
  logic [OFF_W-1:0] r_off;
  color_t           r_col;

  logic              div_start, div_done;
  logic [FRAC_W-1:0] div_quot;
  state_t            end_state;

  logic signed [CB:0]   diff;
  logic signed [PW-1:0] base, sum;

  gscl_stop_ram #(.DEPTH(MAX_STOPS), .WIDTH(WW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  gscl_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(q_r - lo_off), .divisor(hi_off - lo_off),
    .quot(div_quot), .done(div_done)
  );

  assign r_off     = rdata[WW-1:4*CB];
  assign r_col     = rdata[4*CB-1:0];
  assign cur1      = TW'(cur) + TW'(1);
  assign in_stall  = (state != S_IDLE);
  assign div_start = (state == S_PICK) && lo_v && hi_v;
  assign end_state = (cmd_r == CMD_APPEND_INTERP) ? S_APP : S_EMIT;

  // Blend as lo + (hi - lo) * f, so one signed multiplier serves each channel.
  assign diff = $signed({1'b0, hi_col[ch]}) - $signed({1'b0, lo_col[ch]});
  assign base = $signed({2'b00, lo_col[ch], {FRAC_W{1'b0}}});
  assign sum  = base + prod + $signed(PW'(32768));

  always_comb begin
    raddr = iss[IW-1:0];
    we    = 1'b0;
    waddr = cur;
    wdata = rdata;
    case (state)
      S_RM0:   raddr = cur;
      S_RMRD:  raddr = cur1[IW-1:0];
      S_INIT0: begin
        we    = 1'b1;
        waddr = '0;
        wdata = {{OFF_W{1'b0}}, {4{CH_FULL}}};
      end
      S_INIT1: begin
        we    = 1'b1;
        waddr = IW'(1);
        wdata = {OFF_ONE, {4{CH_FULL}}};
      end
      S_APP: begin
        we    = 1'b1;
        waddr = total[IW-1:0];
        wdata = {q_r, col};
      end
      S_RMWR:  we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT0;
      boot      <= 1'b1;
      total     <= TW'(2);
      tcnt      <= '0;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r    <= cmd;
            q_r      <= query_offset;
            col      <= '0;
            status_r <= ST_OK;
            iss      <= '0;
            lo_v     <= 1'b0;
            hi_v     <= 1'b0;
            case (cmd)
              CMD_LOOKUP: begin
                if (total == '0) begin
                  status_r <= ST_EMPTY;
                  state    <= S_EMIT;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_APPEND: begin
                if (total >= TW'(MAX_STOPS)) begin
                  status_r <= ST_FULL;
                  state    <= S_EMIT;
                end else begin
                  col   <= {CB'(color_alpha), CB'(color_blue), CB'(color_green),
                            CB'(color_red)};
                  state <= S_APP;
                end
              end
              CMD_APPEND_INTERP: begin
                if (total >= TW'(MAX_STOPS)) begin
                  status_r <= ST_FULL;
                  state    <= S_EMIT;
                end else if (total == '0) begin
                  status_r <= ST_EMPTY;
                  state    <= S_EMIT;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_REMOVE: begin
                if (CMPW'(stop_index) >= CMPW'(total)) begin
                  status_r <= ST_INDEX;
                  state    <= S_EMIT;
                end else begin
                  cur   <= IW'(stop_index);
                  state <= S_RM0;
                end
              end
              CMD_RESTORE: begin
                boot  <= 1'b0;
                state <= S_INIT0;
              end
              default: state <= S_EMIT;
            endcase
          end
        end
        S_INIT0: state <= S_INIT1;
        S_INIT1: begin
          total <= TW'(2);
          tcnt  <= '0;
          state <= boot ? S_IDLE : S_EMIT;
        end
        S_SCAN: begin
          if (rd_v) begin
            if (rd_first || r_off <= min_off) begin
              min_off <= r_off;
              min_col <= r_col;
            end
            if (rd_first || r_off >= max_off) begin
              max_off <= r_off;
              max_col <= r_col;
            end
            if (r_off < q_r) begin
              if (!lo_v || r_off > lo_off) begin
                lo_v   <= 1'b1;
                lo_off <= r_off;
                lo_col <= r_col;
              end
            end else if (!hi_v || r_off < hi_off) begin
              hi_v   <= 1'b1;
              hi_off <= r_off;
              hi_col <= r_col;
            end
          end
          if (rd_v && r_off == q_r) begin
            // The first exact match in table order wins outright.
            col   <= r_col;
            rd_v  <= 1'b0;
            state <= end_state;
          end else if (iss < total) begin
            iss      <= iss + TW'(1);
            rd_v     <= 1'b1;
            rd_first <= (iss == '0);
          end else begin
            rd_v <= 1'b0;
            if (!rd_v) begin
              state <= S_PICK;
            end
          end
        end
        S_PICK: begin
          if (!hi_v) begin
            col   <= max_col;
            state <= end_state;
          end else if (!lo_v) begin
            col   <= min_col;
            state <= end_state;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            fac   <= div_quot;
            ch    <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= PW'(diff * $signed({1'b0, fac}));
          state <= S_ADD;
        end
        S_ADD: begin
          col[ch] <= sum[FRAC_W+CB-1:FRAC_W];
          ch      <= ch + 2'd1;
          state   <= (ch == 2'd3) ? end_state : S_MUL;
        end
        S_APP: begin
          total <= total + TW'(1);
          if (col[3] != CH_FULL) begin
            tcnt <= tcnt + TW'(1);
          end
          state <= S_EMIT;
        end
        S_RM0: state <= S_RM1;
        S_RM1: begin
          if (r_col[3] != CH_FULL) begin
            tcnt <= tcnt - TW'(1);
          end
          state <= S_RMNX;
        end
        S_RMNX: begin
          if (cur1 < total) begin
            state <= S_RMRD;
          end else begin
            total <= total - TW'(1);
            state <= S_EMIT;
          end
        end
        S_RMRD: state <= S_RMWR;
        S_RMWR: begin
          cur   <= cur1[IW-1:0];
          state <= S_RMNX;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            out_red         <= 16'(col[0]);
            out_green       <= 16'(col[1]);
            out_blue        <= 16'(col[2]);
            out_alpha       <= 16'(col[3]);
            any_transparent <= (tcnt != '0);
            stops_held      <= 5'(total);
            status          <= status_r;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "gradient_stop_color_lookup_assert.svh"

  `GSCL_ASSERT_ALWAYS(a_total_bound, total <= TW'(MAX_STOPS))
  `GSCL_ASSERT_ALWAYS(a_transparent_bound, tcnt <= total)
  `GSCL_ASSERT_IMPLY(a_full_report, out_valid && status == ST_FULL, stops_held == 5'(MAX_STOPS))

endmodule
